FILE: sv/bcrr_pkg.sv
package bcrr_pkg;

    localparam int TAG_W       = 32;
    localparam int BYTE_IDX_W  = 10;
    localparam int DATA_W      = 8;
    localparam int OP_W        = 2;

    localparam int DEF_ENTRIES     = 8;
    localparam int DEF_BLOCK_BYTES = 1024;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
    localparam logic [OP_W-1:0] OP_INVAL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [TAG_W-1:0]      block_num;
        logic [BYTE_IDX_W-1:0] byte_index;
        logic [DATA_W-1:0]     data_byte;
    } t_in_item;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] data_out;
    } t_out_item;

endpackage

FILE: sv/bcrr_tag_array.sv
module bcrr_tag_array #(
    parameter int ENTRIES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [bcrr_pkg::OP_W-1:0]     i_op,
    input  logic [bcrr_pkg::TAG_W-1:0]    i_tag,
    input  logic                          i_first,
    output logic                          o_hit,
    output logic [$clog2(ENTRIES)-1:0]    o_slot
);
    import bcrr_pkg::*;

    localparam int SLOT_W = $clog2(ENTRIES);

    logic [TAG_W-1:0]   r_tag [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [SLOT_W-1:0]  r_victim;
    logic [SLOT_W-1:0]  r_fill;

    logic [ENTRIES-1:0] w_match;
    logic [SLOT_W-1:0]  w_match_slot;
    logic [SLOT_W-1:0]  w_store_slot;
    logic               w_alloc;

    always_comb begin
        w_match_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            w_match[i] = r_valid[i] && (r_tag[i] == i_tag);
            if (w_match[i]) begin
                w_match_slot = SLOT_W'(i);
            end
        end
    end

    assign o_hit        = |w_match;
    assign w_store_slot = o_hit ? w_match_slot : r_victim;
    assign w_alloc      = i_fire && (i_op == OP_STORE) && i_first;

    // Later bytes of a block follow the slot chosen by its first byte.
    always_comb begin
        if (i_op == OP_STORE) begin
            o_slot = i_first ? w_store_slot : r_fill;
        end else begin
            o_slot = w_match_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_alloc) begin
            r_tag[w_store_slot] <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_victim <= '0;
            r_fill   <= '0;
        end else if (i_fire && (i_op == OP_INVAL)) begin
            r_valid  <= '0;
            r_victim <= '0;
        end else if (w_alloc) begin
            r_valid[w_store_slot] <= 1'b1;
            r_fill                <= w_store_slot;
            if (!o_hit) begin
                if (r_victim == SLOT_W'(ENTRIES - 1)) begin
                    r_victim <= '0;
                end else begin
                    r_victim <= r_victim + SLOT_W'(1);
                end
            end
        end
    end

endmodule

FILE: sv/bcrr_data_ram.sv
module bcrr_data_ram #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic                        i_re,
    input  logic [ADDR_W-1:0]           i_addr,
    input  logic [bcrr_pkg::DATA_W-1:0] i_wdata,
    output logic [bcrr_pkg::DATA_W-1:0] o_rdata
);
    import bcrr_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/block_cache_round_robin_unit.sv
// Fully associative block cache of ENTRIES blocks of BLOCK_BYTES bytes
// (BLOCK_BYTES must be a power of two) with round-robin replacement. One
// transaction is taken per cycle while the result side does not stall, and
// each produces exactly one result, held in an output register; the rate is set
// by the single-port byte RAM, which serves one read or one write per cycle,
// and the tag compare, which checks every entry in parallel within that same
// cycle. A store with byte index zero (after wrapping) claims the slot for
// the block and the bytes that follow it go to that slot. The byte store is
// not cleared at reset.
module block_cache_round_robin_unit #(
    parameter int ENTRIES     = bcrr_pkg::DEF_ENTRIES,
    parameter int BLOCK_BYTES = bcrr_pkg::DEF_BLOCK_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bcrr_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bcrr_pkg::t_out_item o_out_data
);
    import bcrr_pkg::*;

    localparam int SLOT_W = $clog2(ENTRIES);
    localparam int IDX_W  = $clog2(BLOCK_BYTES);
    localparam int ADDR_W = SLOT_W + IDX_W;
    localparam int DEPTH  = ENTRIES * BLOCK_BYTES;

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    logic        r_hit;
    logic        r_show_data;

    logic              w_advance;
    logic              w_fire;
    logic [IDX_W-1:0]  w_idx;
    logic              w_first;
    logic              w_hit;
    logic [SLOT_W-1:0] w_slot;
    logic              w_we;
    logic              w_re;
    logic [DATA_W-1:0] w_rdata;

    assign w_advance  = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_advance;
    assign o_in_ready = !r_in_valid || w_advance;

    // Truncation to the index width is the wrap modulo the block size.
    assign w_idx   = IDX_W'(r_in.byte_index);
    assign w_first = (w_idx == '0);

    bcrr_tag_array #(
        .ENTRIES (ENTRIES)
    ) u_tag_array (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_op    (r_in.op),
        .i_tag   (r_in.block_num),
        .i_first (w_first),
        .o_hit   (w_hit),
        .o_slot  (w_slot)
    );

    assign w_we = w_fire && (r_in.op == OP_STORE);
    assign w_re = w_fire && (r_in.op == OP_LOOKUP) && w_hit;

    bcrr_data_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_re    (w_re),
        .i_addr  ({w_slot, w_idx}),
        .i_wdata (r_in.data_byte),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_hit       <= w_hit && ((r_in.op == OP_LOOKUP) || (r_in.op == OP_STORE));
            r_show_data <= w_re;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_data.hit      = r_hit;
    assign o_out_data.data_out = r_show_data ? w_rdata : '0;

    a_data_needs_hit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.data_out == '0) || o_out_data.hit)
        else $error("cached byte returned without a hit");

    a_in_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in))
        else $error("held transaction lost or overwritten");

    a_inval_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && (r_in.op == OP_INVAL) |=> !w_hit)
        else $error("tag hit straight after invalidate");

    a_single_access : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re))
        else $error("byte RAM read and written in the same cycle");

endmodule

FILE: tb/block_cache_round_robin_unit_tb.sv
`timescale 1ns / 1ps

module block_cache_round_robin_unit_tb;
    import bcrr_pkg::*;

    localparam int NUM_ENTRIES  = DEF_ENTRIES;
    localparam int BLOCK_BYTES  = DEF_BLOCK_BYTES;
    localparam int TOTAL_ITEMS  = 1750;
    localparam int POOL_SIZE    = 12;
    localparam int CYCLE_LIMIT  = 200000;

    // The encoding that the block has no operation for.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    class cache_scoreboard;
        logic [TAG_W-1:0]  entry_tag [NUM_ENTRIES];
        bit                entry_valid [NUM_ENTRIES];
        logic [DATA_W-1:0] block_bytes [NUM_ENTRIES*BLOCK_BYTES];
        bit                byte_stored [NUM_ENTRIES*BLOCK_BYTES];
        int unsigned       victim_ptr;
        int unsigned       fill_ptr;
        t_out_item         expected_q [$];
        int unsigned       errors;
        int unsigned       n_checked;
        int unsigned       n_hits;
        int unsigned       n_misses;
        int unsigned       n_stores;
        int unsigned       n_invals;
        int unsigned       n_unknown;

        function int find_entry(logic [TAG_W-1:0] tag);
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                if (entry_valid[i] && entry_tag[i] == tag) begin
                    return i;
                end
            end
            return -1;
        endfunction

        function bit byte_known(int slot, logic [BYTE_IDX_W-1:0] idx);
            return byte_stored[slot*BLOCK_BYTES + (idx % BLOCK_BYTES)];
        endfunction

        // Updates the cache image for one accepted transaction and queues its result.
        function void note_input(t_in_item it);
            int          slot;
            int unsigned idx;
            int unsigned s;
            t_out_item   res;
            res  = '0;
            idx  = it.byte_index % BLOCK_BYTES;
            slot = find_entry(it.block_num);
            case (it.op)
                OP_LOOKUP: begin
                    if (slot >= 0) begin
                        res.hit      = 1'b1;
                        res.data_out = block_bytes[slot*BLOCK_BYTES + idx];
                        n_hits++;
                    end else begin
                        n_misses++;
                    end
                end
                OP_STORE: begin
                    res.hit = (slot >= 0);
                    if (idx == 0) begin
                        if (slot >= 0) begin
                            s = slot;
                        end else begin
                            s          = victim_ptr;
                            victim_ptr = (victim_ptr + 1) % NUM_ENTRIES;
                        end
                        entry_tag[s]   = it.block_num;
                        entry_valid[s] = 1'b1;
                        fill_ptr       = s;
                    end
                    // Later bytes follow the claimed slot, whatever tag they carry.
                    block_bytes[fill_ptr*BLOCK_BYTES + idx] = it.data_byte;
                    byte_stored[fill_ptr*BLOCK_BYTES + idx] = 1'b1;
                    n_stores++;
                end
                OP_INVAL: begin
                    foreach (entry_valid[i]) begin
                        entry_valid[i] = 1'b0;
                    end
                    victim_ptr = 0;
                    n_invals++;
                end
                default: begin
                    n_unknown++;
                end
            endcase
            expected_q.push_back(res);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: hit %0d data_out 0x%02h", got.hit, got.data_out);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            if (got.hit !== want.hit) begin
                $error("hit: expected %0d, actual %0d", want.hit, got.hit);
                errors++;
            end
            if (got.data_out !== want.data_out) begin
                $error("data_out: expected 0x%02h, actual 0x%02h", want.data_out, got.data_out);
                errors++;
            end
        endfunction
    endclass

    cache_scoreboard  sb = new;
    logic [TAG_W-1:0] tag_pool [POOL_SIZE];
    int unsigned      items_sent  = 0;
    int unsigned      idle_pct    = 0;
    int unsigned      stall_left  = 0;
    int unsigned      cycle_count = 0;

    block_cache_round_robin_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("block_cache_round_robin_unit test failed");
            $finish;
        end
    end

    // Result side: stalls come in random bursts.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 3);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out_data);
        end
    end

    function automatic t_in_item make_item(logic [OP_W-1:0] op, logic [TAG_W-1:0] tag,
                                           logic [BYTE_IDX_W-1:0] idx,
                                           logic [DATA_W-1:0] data);
        t_in_item it;
        it.op         = op;
        it.block_num  = tag;
        it.byte_index = idx;
        it.data_byte  = data;
        return it;
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom;
        end
        return tag_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    task automatic send_item(t_in_item it);
        int slot;
        // Byte 0 of a valid entry is always written, so a lookup that would read
        // a byte never stored is moved onto byte 0 of the same block.
        if (it.op == OP_LOOKUP) begin
            slot = sb.find_entry(it.block_num);
            if (slot >= 0 && !sb.byte_known(slot, it.byte_index)) begin
                it.byte_index = '0;
            end
        end
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic store_block(logic [TAG_W-1:0] tag, int unsigned n_bytes);
        for (int k = 0; k < n_bytes; k++) begin
            send_item(make_item(OP_STORE, tag, BYTE_IDX_W'(k), DATA_W'($urandom)));
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int unsigned r;
        int unsigned n;
        bit          paused;
        paused      = 1'b0;
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            tag_pool[i] = $urandom;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 20;
        send_item(make_item(OP_LOOKUP, '0, '0, '0));
        send_item(make_item(OP_LOOKUP, '1, '1, '0));
        send_item(make_item(OP_UNUSED, '1, '1, '1));
        // A later byte with no block claimed lands in the fill slot left by reset.
        send_item(make_item(OP_STORE, 32'h1234_5678, 10'd5, 8'hA5));
        send_item(make_item(OP_STORE, '1, '0, '1));
        send_item(make_item(OP_STORE, '1, '1, '0));
        send_item(make_item(OP_LOOKUP, '1, '0, '0));
        send_item(make_item(OP_LOOKUP, '1, '1, '0));
        send_item(make_item(OP_LOOKUP, '1, 10'd5, '0));
        send_item(make_item(OP_STORE, '0, '0, 8'h5A));
        // Restarting a cached block reuses its entry and leaves the pointer alone.
        send_item(make_item(OP_STORE, '1, '0, 8'hC3));
        for (int t = 2; t <= 8; t++) begin
            send_item(make_item(OP_STORE, TAG_W'(t), '0, DATA_W'(t)));
        end
        send_item(make_item(OP_LOOKUP, '1, '0, '0));
        send_item(make_item(OP_LOOKUP, 32'd8, '0, '0));
        send_item(make_item(OP_INVAL, 32'd8, '0, '0));
        send_item(make_item(OP_LOOKUP, 32'd8, '0, '0));
        send_item(make_item(OP_STORE, 32'd8, 10'd3, 8'h3C));
        send_item(make_item(OP_STORE, 32'd9, '0, 8'h96));
        send_item(make_item(OP_LOOKUP, 32'd9, 10'd3, '0));
        drain_results();

        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent < 600) begin
                idle_pct = 25;
            end else if (items_sent < 900) begin
                idle_pct = 0;
            end else if (items_sent < 1400) begin
                idle_pct = 45;
            end else if (items_sent < 1550) begin
                idle_pct = 15;
            end else begin
                idle_pct = 0;
            end
            if (!paused && items_sent >= 1000) begin
                drain_results();
                repeat (3) @(posedge i_clk);
                paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 30) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
                store_block(tag_pool[$urandom_range(0, POOL_SIZE - 1)], n);
            end else if (r < 75) begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15);
                send_item(make_item(OP_LOOKUP, pick_tag(), BYTE_IDX_W'(n), DATA_W'($urandom)));
            end else if (r < 78) begin
                send_item(make_item(OP_INVAL, $urandom, BYTE_IDX_W'($urandom),
                                    DATA_W'($urandom)));
            end else begin
                send_item(make_item(OP_W'($urandom_range(0, 3)), pick_tag(),
                                    BYTE_IDX_W'($urandom), DATA_W'($urandom)));
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d transactions: %0d lookup hits, %0d lookup misses, %0d byte stores,",
                 items_sent, sb.n_hits, sb.n_misses, sb.n_stores);
        $display("%0d invalidates, %0d unused-op transactions; %0d results checked, %0d mismatches.",
                 sb.n_invals, sb.n_unknown, sb.n_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("block_cache_round_robin_unit test passed");
        end else begin
            $display("block_cache_round_robin_unit test failed");
        end
        $finish;
    end

endmodule
